// File: rtl/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared constants and types for the distinct substring counter.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int MaxLen   = 1024;
  localparam int AddrW    = $clog2(MaxLen);
  localparam int LenW     = $clog2(MaxLen + 1);
  localparam int NewW     = 11;
  localparam int TotalW   = 20;
  localparam int InDataW  = 8;
  localparam int OutDataW = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FETCH,
    ST_SEED,
    ST_READ,
    ST_CMP,
    ST_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // latch input byte, clear or set drop
    logic start;   // append byte, begin scan at i=1
    logic seed;    // compute initial z for position i
    logic read;    // read state; unused by the datapath, whose byte reads for z and i+z are unconditional
    logic cmp;     // extend z on a match with i+z < n, else close position i
    logic finish;  // update totals unless dropped, load output
  } dsc_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic full;       // byte is dropped
    logic scan_done;  // i reached n
    logic ext_ok;     // i+z < n, a comparison is needed
    logic match;      // compared bytes are equal
  } dsc_sts_t;

endpackage

// File: rtl/dsc_ctrl.sv
// ----------------------------------------------------------------------------
// dsc_ctrl
// Sequencer for the Z-function scan: two byte reads and one compare per step.
// ----------------------------------------------------------------------------
module dsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dsc_pkg::dsc_sts_t sts_i,
  output dsc_pkg::dsc_cmd_t cmd_o
);
  import dsc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        ovalid_q, ovalid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i && !ovalid_q) state_d = ST_START;
      ST_START: state_d = sts_i.full ? ST_DONE : ST_FETCH;
      // previous Z value is read here, in the state before seeding
      ST_FETCH: state_d = sts_i.scan_done ? ST_DONE : ST_SEED;
      ST_SEED:  state_d = ST_READ;
      ST_READ:  state_d = ST_CMP;
      // the compare either extends z or closes the position
      ST_CMP:   state_d = (sts_i.match && sts_i.ext_ok) ? ST_READ : ST_FETCH;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    in_ready_o   = (state_q == ST_IDLE) && !ovalid_q;
    cmd_o.accept = in_ready_o && in_valid_i;
    case (state_q)
      ST_START: cmd_o.start  = !sts_i.full;
      ST_SEED:  cmd_o.seed   = 1'b1;
      ST_READ:  cmd_o.read   = 1'b1;
      ST_CMP:   cmd_o.cmp    = 1'b1;
      ST_DONE:  cmd_o.finish = 1'b1;
      default:  ;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (out_ready_i) ovalid_d = 1'b0;
    if (state_q == ST_DONE) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

// File: rtl/dsc_dp.sv
// ----------------------------------------------------------------------------
// dsc_dp
// Prefix and Z-value memories, scan registers and counters.
// ----------------------------------------------------------------------------
module dsc_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [dsc_pkg::InDataW-1:0]    symbol_i,
  input  logic                           begin_string_i,
  input  dsc_pkg::dsc_cmd_t              cmd_i,
  output dsc_pkg::dsc_sts_t              sts_o,
  output logic [dsc_pkg::OutDataW-1:0]   result_o
);
  import dsc_pkg::*;

  logic [7:0]        prefix_mem [MaxLen];
  logic [NewW-1:0]   zval_mem   [MaxLen];

  logic [LenW-1:0]   len_q;
  logic [TotalW-1:0] total_q;
  logic [7:0]        sym_q;
  logic              drop_q;
  logic [LenW-1:0]   i_q, z_q, lo_q, hi_q, best_q;
  logic [7:0]        rd_a_q, rd_b_q;
  logic [NewW-1:0]   zrd_q;
  logic [OutDataW-1:0] res_q;

  logic              full;
  logic              extend;
  logic [LenW:0]     iz;
  logic [LenW-1:0]   room, zinit, fresh;
  logic [TotalW:0]   sum;

  assign full  = (len_q == LenW'(MaxLen));
  assign iz    = {1'b0, i_q} + {1'b0, z_q};
  assign room  = hi_q - i_q + LenW'(1);
  // previous Z value is read during the cycle before seeding
  assign zinit = (lo_q != '0 && i_q <= hi_q) ?
                 ((LenW'(zrd_q) < room) ? LenW'(zrd_q) : room) : '0;
  assign fresh = len_q - best_q;
  assign sum   = {1'b0, total_q} + (TotalW + 1)'(fresh);

  assign sts_o.full      = drop_q;
  assign sts_o.scan_done = (i_q >= len_q);
  assign sts_o.ext_ok    = (iz < {1'b0, len_q});
  assign sts_o.match     = (rd_a_q == rd_b_q);

  assign extend = sts_o.match && sts_o.ext_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) prefix_mem[len_q[AddrW-1:0]] <= sym_q;
    // byte k of reversed prefix sits at n-1-k
    rd_a_q <= prefix_mem[AddrW'(len_q - LenW'(1) - z_q)];
    rd_b_q <= prefix_mem[AddrW'(len_q - LenW'(1) - iz[LenW-1:0])];
    zrd_q  <= zval_mem[AddrW'(i_q - lo_q)];
    if (cmd_i.cmp && !extend) zval_mem[AddrW'(i_q)] <= NewW'(z_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      total_q  <= '0;
      drop_q   <= 1'b0;
      i_q      <= '0;
      z_q      <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      best_q   <= '0;
      sym_q    <= '0;
      res_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        sym_q <= symbol_i;
        if (begin_string_i) begin
          len_q   <= '0;
          total_q <= '0;
          drop_q  <= 1'b0;
        end else begin
          drop_q <= full;
        end
      end
      if (cmd_i.start) begin
        len_q    <= len_q + LenW'(1);
        i_q      <= LenW'(1);
        lo_q     <= '0;
        hi_q     <= '0;
        best_q   <= '0;
      end
      if (cmd_i.seed) z_q <= zinit;
      if (cmd_i.cmp) begin
        if (extend) begin
          lo_q <= i_q;
          hi_q <= iz[LenW-1:0];
          z_q  <= z_q + LenW'(1);
        end else begin
          // position closed: record best, advance
          if (z_q > best_q) best_q <= z_q;
          i_q <= i_q + LenW'(1);
        end
      end
      if (cmd_i.finish) begin
        if (drop_q) begin
          res_q <= {1'b1, total_q, NewW'(0)};
        end else begin
          total_q <= sum[TotalW] ? '1 : sum[TotalW-1:0];
          res_q   <= {1'b0, (sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0]),
                      ((LenW > NewW) && (fresh > LenW'({NewW{1'b1}}))) ?
                      {NewW{1'b1}} : NewW'(fresh)};
        end
      end
    end
  end

  assign result_o = res_q;

endmodule

// File: rtl/distinct_substring_counter_unit.sv
// ----------------------------------------------------------------------------
// distinct_substring_counter_unit
// Counts distinct substrings of a byte stream with a Z-function scan.
// ----------------------------------------------------------------------------
// One byte per transaction. Each byte runs a Z-function pass over the reversed
// stored prefix of length n. Every position costs a fetch of the earlier Z
// value, a seed step, and a read/compare pair per byte match plus one more
// pair for the closing compare. Matches over one pass stay below n, which
// bounds the scan loop in the controller. A byte arriving on a full buffer
// goes from the start state straight to the done state and gives overflow.
// One item is in flight at a time; the input is ready again in the cycle
// after the result is taken.
module distinct_substring_counter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic        s_axis_tuser,   // [0] begin_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [10:0] new_count, [30:11] total_count,
                                      // [31] overflow
);
  import dsc_pkg::*;

  dsc_cmd_t cmd;
  dsc_sts_t sts;

  dsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dsc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .symbol_i       (s_axis_tdata),
    .begin_string_i (s_axis_tuser),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_o       (m_axis_tdata)
  );

endmodule

// File: rtl/dsc_checker.sv
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks for the distinct substring counter.
// ----------------------------------------------------------------------------
module dsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a pending result holds its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no new byte taken while a result waits
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready with result pending");

  // an overflow result reports no new substrings
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[10:0] == 11'd0)
    else $error("overflow with nonzero count");

  // acceptance closes the input until the result is out
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transaction");

endmodule

bind distinct_substring_counter_unit dsc_checker u_dsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte strings into the distinct substring counter and checks every
// result against a behavioral Z-function count kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
  import dsc_pkg::*;

  localparam int NewMax   = 2047;
  localparam int TotalMax = 1048575;

  typedef struct packed {
    logic              ovf;
    logic [TotalW-1:0] total;
    logic [NewW-1:0]   fresh;
  } count_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  distinct_substring_counter_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #20000000;
    $display("testbench: errors");
    $finish;
  end

  // bench copy of the block state
  logic [7:0]        str_bytes [MaxLen];
  int                z_vals [MaxLen];
  int                str_len;
  int                sum_total;
  count_t            expected_counts [$];
  int                errors;
  int                send_idle_pct;
  int                recv_stall_pct;

  function automatic logic [7:0] rev_byte(int n, int k);
    return str_bytes[n - 1 - k];
  endfunction

  function automatic count_t count_substrings(logic [7:0] sym, logic clear);
    count_t r;
    int lo, hi, best, z, a, b, n;
    if (clear) begin
      str_len   = 0;
      sum_total = 0;
    end
    if (str_len >= MaxLen) begin
      r.fresh = '0;
      r.total = TotalW'(sum_total);
      r.ovf   = 1'b1;
      return r;
    end
    str_bytes[str_len] = sym;
    str_len++;
    n = str_len;
    lo = 0; hi = 0; best = 0;
    for (int i = 1; i < n; i++) begin
      z = 0;
      if (lo > 0 && i <= hi) begin
        a = z_vals[i - lo];
        b = hi - i + 1;
        z = a < b ? a : b;
      end
      while (i + z < n && rev_byte(n, z) == rev_byte(n, i + z)) begin
        lo = i;
        hi = i + z;
        z++;
      end
      z_vals[i] = z;
      if (z > best) best = z;
    end
    sum_total = sum_total + (n - best);
    if (sum_total > TotalMax) sum_total = TotalMax;
    r.fresh = NewW'((n - best) > NewMax ? NewMax : (n - best));
    r.total = TotalW'(sum_total);
    r.ovf   = 1'b0;
    return r;
  endfunction

  // valid stays up between back-to-back transactions
  task automatic send_byte(logic [7:0] sym, logic clear);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    expected_counts.push_back(count_substrings(sym, clear));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tuser  <= clear;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // receiver: random stalls, compares each transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errors++;
        end else begin
          count_t e;
          e = expected_counts.pop_front();
          if (m_axis_tdata[NewW-1:0] !== e.fresh) begin
            $display("%0t: new_count exp %0d got %0d", $time, e.fresh,
                     m_axis_tdata[NewW-1:0]);
            errors++;
          end
          if (m_axis_tdata[NewW+TotalW-1:NewW] !== e.total) begin
            $display("%0t: total_count exp %0d got %0d", $time, e.total,
                     m_axis_tdata[NewW+TotalW-1:NewW]);
            errors++;
          end
          if (m_axis_tdata[31] !== e.ovf) begin
            $display("%0t: overflow exp %0b got %0b", $time, e.ovf,
                     m_axis_tdata[31]);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (expected_counts.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    for (int i = 0; i < 6; i++) send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_random(int n_items);
    for (int i = 0; i < n_items; i++) begin
      logic [7:0] sym;
      sym = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(2) + 8'h61);
      send_byte(sym, $urandom_range(15) == 0);
    end
  endtask

  initial begin
    errors = 0;
    str_len = 0;
    sum_total = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(70);
    send_idle_pct = 68;
    test_random(70);
    send_idle_pct = 0;
    recv_stall_pct = 68;
    test_random(70);
    send_idle_pct = 18;
    recv_stall_pct = 18;
    test_random(60);
    s_axis_tvalid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_counts.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dsc_pkg.sv
rtl/dsc_ctrl.sv
rtl/dsc_dp.sv
rtl/distinct_substring_counter_unit.sv
rtl/dsc_checker.sv
tb/testbench.sv
